// ===== sv/fdcw_pkg.sv =====
// Package for the control-word decryptor: shared types, tables and bit-mapping functions.
// Used by fdcw_lane; depends on nothing.
package fdcw_pkg;

  typedef logic [63:0] block_t;

  typedef struct packed {
    logic [63:0] blk;
    logic [63:0] key;
  } lane_st_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h1F,8'hB0,8'h28,8'hEB,8'hD1,8'h0D,8'h42,8'h7E,8'hC5,8'h59,8'h93,8'h34,8'hA6,8'h6A,8'hFC,8'h87,
      8'hB0,8'hE3,8'h17,8'h7D,8'h2B,8'h96,8'hDE,8'h48,8'h0A,8'h34,8'h6C,8'h81,8'hC5,8'h5F,8'hA9,8'hF2,
      8'h2E,8'hD0,8'h72,8'hB7,8'h95,8'h0C,8'h48,8'hEB,8'h53,8'h6A,8'hC9,8'h14,8'hAF,8'hF1,8'h36,8'h8D,
      8'h8D,8'h4E,8'hB1,8'hE8,8'h6B,8'h35,8'h17,8'hD2,8'hF0,8'h93,8'h56,8'h2F,8'h0C,8'hCA,8'hA9,8'h74,
      8'hB2,8'h4F,8'hD4,8'h18,8'h0B,8'hF6,8'h7E,8'h25,8'hC1,8'h3C,8'h6A,8'h83,8'hAD,8'h50,8'h97,8'hE9,
      8'hE9,8'hB4,8'h42,8'h27,8'h3E,8'hCB,8'h85,8'h18,8'h56,8'h0A,8'h9F,8'h70,8'hF1,8'hAD,8'h6C,8'hD3,
      8'h35,8'hE0,8'h5B,8'h0D,8'h68,8'hD3,8'h96,8'h7A,8'hF9,8'h2E,8'hC2,8'hB1,8'h1F,8'h84,8'hAC,8'h47,
      8'h6B,8'h1C,8'h0D,8'hA3,8'hD6,8'h7A,8'h30,8'hC5,8'h84,8'hF1,8'hBE,8'h58,8'hE9,8'h2F,8'h47,8'h92,
      8'hD1,8'h34,8'hBD,8'hE3,8'h8B,8'h58,8'h42,8'h9E,8'h7A,8'hAF,8'hC0,8'h05,8'h2C,8'hF6,8'h17,8'h69,
      8'hB4,8'hD7,8'hE3,8'h48,8'h5E,8'h21,8'h8D,8'h72,8'h09,8'h60,8'h3F,8'hA6,8'h95,8'hCB,8'hFA,8'h1C,
      8'h82,8'h27,8'h14,8'hCA,8'hF9,8'h90,8'h6F,8'h5C,8'hEB,8'hD8,8'h7D,8'hA3,8'h4E,8'h35,8'hB1,8'h06,
      8'h5C,8'h90,8'h6F,8'hF9,8'h35,8'h4E,8'h82,8'h27,8'h06,8'hEB,8'hCA,8'h14,8'hA3,8'hD8,8'h7D,8'hB1,
      8'h52,8'hF8,8'h6F,8'h16,8'h9C,8'hCB,8'h09,8'hA5,8'hED,8'h27,8'h3A,8'h81,8'h43,8'hB4,8'hD0,8'h7E,
      8'h2E,8'h95,8'hB2,8'h6F,8'h79,8'h06,8'hC7,8'hF8,8'h4B,8'hE0,8'hD1,8'h3C,8'hA4,8'h5A,8'h1D,8'h83,
      8'h0C,8'hE2,8'h7B,8'h18,8'h90,8'h4D,8'hC7,8'hB1,8'h63,8'h8F,8'hDE,8'h25,8'h39,8'hF6,8'hA4,8'h5A,
      8'hF2,8'h17,8'h85,8'h4E,8'h5C,8'hB0,8'h2B,8'hED,8'hA4,8'h79,8'h38,8'h93,8'h6F,8'hCA,8'hD1,8'h06};
    return t[a];
  endfunction

  localparam logic [5:0] KEY_SEL [48] = '{
    6'h1C,6'h1F,6'h18,6'h0A,6'h12,6'h0E,6'h07,6'h1A,6'h04,6'h15,6'h0B,6'h10,6'h0C,6'h1B,6'h0F,6'h09,
    6'h14,6'h1E,6'h05,6'h0D,6'h17,6'h1D,6'h08,6'h13,6'h3E,6'h33,6'h2C,6'h25,6'h39,6'h30,6'h38,6'h26,
    6'h3C,6'h34,6'h2D,6'h29,6'h36,6'h2B,6'h3A,6'h31,6'h24,6'h3D,6'h3B,6'h3F,6'h28,6'h35,6'h2F,6'h32};

  localparam logic [5:0] TEXT_SEL [48] = '{
    6'h1F,6'h00,6'h01,6'h02,6'h03,6'h04,6'h03,6'h04,6'h05,6'h06,6'h07,6'h08,6'h07,6'h08,6'h09,6'h0A,
    6'h0B,6'h0C,6'h0B,6'h0C,6'h0D,6'h0E,6'h0F,6'h10,6'h0F,6'h10,6'h11,6'h12,6'h13,6'h14,6'h13,6'h14,
    6'h15,6'h16,6'h17,6'h18,6'h17,6'h18,6'h19,6'h1A,6'h1B,6'h1C,6'h1B,6'h1C,6'h1D,6'h1E,6'h1F,6'h00};

  localparam logic [6:0] SCATTER [32] = '{
    7'h31,7'h12,7'h50,7'h33,7'h13,7'h21,7'h42,7'h00,7'h51,7'h52,7'h30,7'h43,7'h53,7'h70,7'h22,
    7'h03,7'h73,7'h62,7'h41,7'h60,7'h23,7'h20,7'h02,7'h01,7'h61,7'h63,7'h40,7'h32,7'h10,7'h11,
    7'h71,7'h72};

  localparam logic [1:0] ROT_AMT [16] = '{
    2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0};

  localparam logic [2:0] LANE_KEY [8] = '{3'd0,3'd3,3'd2,3'd1,3'd4,3'd5,3'd6,3'd7};
  localparam logic [2:0] LANE_INIT [8] = '{3'd4,3'd0,3'd5,3'd1,3'd6,3'd2,3'd7,3'd3};
  localparam logic [2:0] LANE_FINAL [8] = '{3'd7,3'd3,3'd6,3'd2,3'd5,3'd1,3'd4,3'd0};

  // Bit n of source byte s lands in byte map[n] at bit 7 - s.
  function automatic block_t spread(input block_t src, input logic [2:0] map [8]);
    block_t d;
    d = '0;
    for (int s = 0; s < 8; s++) begin
      for (int n = 0; n < 8; n++) begin
        d[map[n] * 8 + 7 - s] = src[s * 8 + n];
      end
    end
    return d;
  endfunction

  // Inverse direction: output byte s bit (7-n) takes bit (7-s) of source byte map[n].
  function automatic block_t gather(input block_t src, input logic [2:0] map [8]);
    block_t d;
    d = '0;
    for (int s = 0; s < 8; s++) begin
      for (int n = 0; n < 8; n++) begin
        d[s * 8 + 7 - n] = src[map[n] * 8 + 7 - s];
      end
    end
    return d;
  endfunction

  function automatic logic [63:0] rot1(input logic [63:0] k);
    logic [63:0] r;
    r = k;
    r[23:0] = k[24:1];
    r[31:24] = {k[4], k[31:25]};
    r[55:32] = k[56:33];
    r[63:56] = {k[36], k[63:57]};
    return r;
  endfunction

  function automatic lane_st_t round_fn(input lane_st_t st, input logic [1:0] amt);
    lane_st_t o;
    logic [5:0] x;
    logic [7:0] sb;
    logic [31:0] r;
    logic [6:0] sc;
    int pos;
    r = '0;
    pos = 31;
    for (int g = 0; g < 8; g++) begin
      for (int b = 0; b < 6; b++) begin
        x[b] = st.key[KEY_SEL[(7 - g) * 6 + b]] ^ st.blk[TEXT_SEL[(7 - g) * 6 + b]];
      end
      sb = sbox({3'(8 - g), x[5:1]});
      if (x[0]) begin
        sb = {sb[3:0], 4'h0};
      end
      for (int n = 0; n < 4; n++) begin
        sc = SCATTER[pos];
        r[sc[1:0] * 8 + sc[6:4]] = ~sb[7 - n];
        pos = pos - 1;
      end
    end
    o.blk = {st.blk[31:0], r ^ st.blk[63:32]};
    o.key = st.key;
    if (amt != 2'd0) begin
      o.key = rot1(o.key);
    end
    if (amt == 2'd2) begin
      o.key = rot1(o.key);
    end
    return o;
  endfunction

endpackage

// ===== sv/fdcw_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface fdcw_if #(parameter int W = 128) (input logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/fdcw_lane.sv =====
// One decryption lane: key and text preparation, a registered stage per round, final permutation.
// Depends on fdcw_pkg.
module fdcw_lane #(
  parameter int ROUNDS = 16
) (
  input  logic clk,
  input  logic en,
  input  logic [63:0] word,
  input  logic [63:0] master_key,
  output logic [63:0] result
);
  fdcw_pkg::lane_st_t st [ROUNDS+1];
  fdcw_pkg::lane_st_t first;
  logic [63:0] k56;

  always_comb begin
    k56 = fdcw_pkg::spread(master_key, fdcw_pkg::LANE_KEY);
    k56[7:0] = {k56[35:32], 4'h0};
    first.key = k56;
    first.blk = fdcw_pkg::spread(word, fdcw_pkg::LANE_INIT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= first;
    end
  end

  for (genvar i = 0; i < ROUNDS; i++) begin : g_rnd
    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= fdcw_pkg::round_fn(st[i], fdcw_pkg::ROT_AMT[i % 16]);
      end
    end
  end

  assign result = fdcw_pkg::gather(st[ROUNDS].blk, fdcw_pkg::LANE_FINAL);
endmodule

// ===== sv/feistel_des_control_word_decrypt.sv =====
// Control-word decryptor top level: two parallel cipher lanes and the merging output stage.
// Requests pass input, round and output registers; one is taken each cycle unless stalled.
// The pipeline stalls as a whole while a finished result is not taken.
// Synchronous reset clears the valid bits and master_key to zero.
// Depends on fdcw_pkg, fdcw_if and fdcw_lane.
module feistel_des_control_word_decrypt #(
  parameter int ROUNDS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [63:0] cfg_data,
  fdcw_if.sink in_ch,
  fdcw_if.source out_ch
);
  localparam int DEPTH = ROUNDS + 2;
  logic [63:0] master_key;
  logic [DEPTH-1:0] vld;
  logic en;
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] cw;
  logic [15:0] date;
  logic [63:0] control_word;
  logic [7:0] extra_byte;
  logic [15:0] date_word;

  assign en = !vld[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_key <= '0;
      vld <= '0;
    end else begin
      if (cfg_we) begin
        master_key <= cfg_data;
      end
      if (en) begin
        vld <= {vld[DEPTH-2:0], in_ch.valid};
      end
    end
  end

  fdcw_lane #(.ROUNDS(ROUNDS)) u_lane_a (
    .clk(clk), .en(en), .word(in_ch.data[63:0]), .master_key(master_key), .result(a));
  fdcw_lane #(.ROUNDS(ROUNDS)) u_lane_b (
    .clk(clk), .en(en), .word(in_ch.data[127:64]), .master_key(master_key), .result(b));

  always_comb begin
    cw[31:0] = {1'b0, b[62:32]};
    cw[39:32] = {a[6:0], b[63]};
    cw[47:40] = {a[14:8], a[7]};
    cw[55:48] = {a[22:16], a[15]};
    cw[63:56] = {3'b000, a[27:24], a[23]};
    date = (b[15:0] == 16'hFFFF) ? b[31:16] : b[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      control_word <= cw;
      extra_byte <= a[55:48];
      date_word <= date;
    end
  end

  assign out_ch.valid = vld[DEPTH-1];
  assign out_ch.data = {date_word, extra_byte, control_word};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while stalled");
  a_top: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> control_word[63:61] == 3'b000 && control_word[31] == 1'b0)
    else $error("control word packing broken");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("stalled with empty output");
endmodule

// ===== bench/feistel_des_control_word_decrypt_test.sv =====
// Testbench for the control-word decryptor: directed and random requests checked against
// an in-bench Feistel predictor, with random stalls on both channels and key changes.
// Depends on fdcw_if and feistel_des_control_word_decrypt.
`timescale 1ns / 100ps

module feistel_des_control_word_decrypt_test;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT = 25;

  localparam logic [7:0][2:0] MAP_KEY =
    {3'd7, 3'd6, 3'd5, 3'd4, 3'd1, 3'd2, 3'd3, 3'd0};
  localparam logic [7:0][2:0] MAP_INIT =
    {3'd3, 3'd7, 3'd2, 3'd6, 3'd1, 3'd5, 3'd0, 3'd4};
  localparam logic [7:0][2:0] MAP_FINAL =
    {3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd7};

  localparam logic [7:0] SBOX [256] = '{
    8'h1F,8'hB0,8'h28,8'hEB,8'hD1,8'h0D,8'h42,8'h7E,8'hC5,8'h59,8'h93,8'h34,8'hA6,8'h6A,8'hFC,8'h87,
    8'hB0,8'hE3,8'h17,8'h7D,8'h2B,8'h96,8'hDE,8'h48,8'h0A,8'h34,8'h6C,8'h81,8'hC5,8'h5F,8'hA9,8'hF2,
    8'h2E,8'hD0,8'h72,8'hB7,8'h95,8'h0C,8'h48,8'hEB,8'h53,8'h6A,8'hC9,8'h14,8'hAF,8'hF1,8'h36,8'h8D,
    8'h8D,8'h4E,8'hB1,8'hE8,8'h6B,8'h35,8'h17,8'hD2,8'hF0,8'h93,8'h56,8'h2F,8'h0C,8'hCA,8'hA9,8'h74,
    8'hB2,8'h4F,8'hD4,8'h18,8'h0B,8'hF6,8'h7E,8'h25,8'hC1,8'h3C,8'h6A,8'h83,8'hAD,8'h50,8'h97,8'hE9,
    8'hE9,8'hB4,8'h42,8'h27,8'h3E,8'hCB,8'h85,8'h18,8'h56,8'h0A,8'h9F,8'h70,8'hF1,8'hAD,8'h6C,8'hD3,
    8'h35,8'hE0,8'h5B,8'h0D,8'h68,8'hD3,8'h96,8'h7A,8'hF9,8'h2E,8'hC2,8'hB1,8'h1F,8'h84,8'hAC,8'h47,
    8'h6B,8'h1C,8'h0D,8'hA3,8'hD6,8'h7A,8'h30,8'hC5,8'h84,8'hF1,8'hBE,8'h58,8'hE9,8'h2F,8'h47,8'h92,
    8'hD1,8'h34,8'hBD,8'hE3,8'h8B,8'h58,8'h42,8'h9E,8'h7A,8'hAF,8'hC0,8'h05,8'h2C,8'hF6,8'h17,8'h69,
    8'hB4,8'hD7,8'hE3,8'h48,8'h5E,8'h21,8'h8D,8'h72,8'h09,8'h60,8'h3F,8'hA6,8'h95,8'hCB,8'hFA,8'h1C,
    8'h82,8'h27,8'h14,8'hCA,8'hF9,8'h90,8'h6F,8'h5C,8'hEB,8'hD8,8'h7D,8'hA3,8'h4E,8'h35,8'hB1,8'h06,
    8'h5C,8'h90,8'h6F,8'hF9,8'h35,8'h4E,8'h82,8'h27,8'h06,8'hEB,8'hCA,8'h14,8'hA3,8'hD8,8'h7D,8'hB1,
    8'h52,8'hF8,8'h6F,8'h16,8'h9C,8'hCB,8'h09,8'hA5,8'hED,8'h27,8'h3A,8'h81,8'h43,8'hB4,8'hD0,8'h7E,
    8'h2E,8'h95,8'hB2,8'h6F,8'h79,8'h06,8'hC7,8'hF8,8'h4B,8'hE0,8'hD1,8'h3C,8'hA4,8'h5A,8'h1D,8'h83,
    8'h0C,8'hE2,8'h7B,8'h18,8'h90,8'h4D,8'hC7,8'hB1,8'h63,8'h8F,8'hDE,8'h25,8'h39,8'hF6,8'hA4,8'h5A,
    8'hF2,8'h17,8'h85,8'h4E,8'h5C,8'hB0,8'h2B,8'hED,8'hA4,8'h79,8'h38,8'h93,8'h6F,8'hCA,8'hD1,8'h06};

  localparam logic [7:0] KEY_PICK [48] = '{
    8'h1C,8'h1F,8'h18,8'h0A,8'h12,8'h0E,8'h07,8'h1A,8'h04,8'h15,8'h0B,8'h10,8'h0C,8'h1B,8'h0F,8'h09,
    8'h14,8'h1E,8'h05,8'h0D,8'h17,8'h1D,8'h08,8'h13,8'h3E,8'h33,8'h2C,8'h25,8'h39,8'h30,8'h38,8'h26,
    8'h3C,8'h34,8'h2D,8'h29,8'h36,8'h2B,8'h3A,8'h31,8'h24,8'h3D,8'h3B,8'h3F,8'h28,8'h35,8'h2F,8'h32};

  localparam logic [7:0] TEXT_PICK [48] = '{
    8'h1F,8'h00,8'h01,8'h02,8'h03,8'h04,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h07,8'h08,8'h09,8'h0A,
    8'h0B,8'h0C,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,8'h10,8'h0F,8'h10,8'h11,8'h12,8'h13,8'h14,8'h13,8'h14,
    8'h15,8'h16,8'h17,8'h18,8'h17,8'h18,8'h19,8'h1A,8'h1B,8'h1C,8'h1B,8'h1C,8'h1D,8'h1E,8'h1F,8'h00};

  localparam logic [7:0] BIT_SCATTER [32] = '{
    8'h31,8'h12,8'h50,8'h33,8'h13,8'h21,8'h42,8'h00,8'h51,8'h52,8'h30,8'h43,8'h53,8'h70,8'h22,8'h03,
    8'h73,8'h62,8'h41,8'h60,8'h23,8'h20,8'h02,8'h01,8'h61,8'h63,8'h40,8'h32,8'h10,8'h11,8'h71,8'h72};

  localparam int SHIFT_COUNT [16] = '{1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1, 0};

  typedef struct {
    logic [63:0] control_word;
    logic [7:0]  extra_byte;
    logic [15:0] date_word;
  } control_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [63:0] cfg_data;

  fdcw_if #(.W(128)) in_ch (clk);
  fdcw_if #(.W(88)) out_ch (clk);

  feistel_des_control_word_decrypt DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  control_result_t pending_words[$];
  logic [63:0] round_keys [16];
  int final_pos [64];
  int init_pos [64];
  int error_count = 0;
  int cycle_count = 0;
  int hold_cycles = 0;
  bit quiet = 0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [63:0] spread_lanes(input logic [63:0] w,
                                               input logic [7:0][2:0] m);
    logic [63:0] t;
    logic [63:0] d;
    int dd;
    t = w;
    d = '0;
    for (int s = 7; s >= 0; s--) begin
      for (int n = 0; n < 8; n++) begin
        dd = m[n];
        d[8*dd +: 8] = {t[8*s], d[8*dd+1 +: 7]};
        t[8*s +: 8] = t[8*s +: 8] >> 1;
      end
    end
    return d;
  endfunction

  function automatic logic [63:0] gather_lanes(input logic [63:0] w,
                                               input logic [7:0][2:0] m);
    logic [63:0] t;
    logic [63:0] d;
    int q;
    t = w;
    d = '0;
    for (int s = 7; s >= 0; s--) begin
      for (int n = 0; n < 8; n++) begin
        q = m[n];
        d[8*s +: 8] = {d[8*s +: 7], t[8*q]};
        t[8*q +: 8] = t[8*q +: 8] >> 1;
      end
    end
    return d;
  endfunction

  function automatic logic [31:0] mix_half(input logic [63:0] k, input logic [31:0] lo);
    logic [31:0] r;
    logic [5:0] xk;
    logic [5:0] xt;
    logic [5:0] x;
    logic [7:0] sb;
    logic [7:0] sc;
    logic [63:0] blk;
    int pos;
    int d;
    r = '0;
    pos = 31;
    blk = {32'h0, lo};
    for (int g = 0; g < 8; g++) begin
      xk = '0;
      xt = '0;
      for (int b = 5; b >= 0; b--) begin
        d = KEY_PICK[(7 - g) * 6 + b] & 8'h3F;
        xk = {xk[4:0], k[d]};
        d = TEXT_PICK[(7 - g) * 6 + b] & 8'h3F;
        xt = {xt[4:0], blk[d]};
      end
      x = xk ^ xt;
      sb = SBOX[{3'(8 - g), x[5:1]}];
      if (x[0]) begin
        sb = {sb[3:0], 4'h0};
      end
      for (int n = 0; n < 4; n++) begin
        sc = BIT_SCATTER[pos];
        r[8 * sc[1:0] + sc[6:4]] = ~sb[7];
        sb = sb << 1;
        pos--;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] rotate_halves(input logic [63:0] k, input int amount);
    logic [63:0] t;
    t = k;
    for (int n = 0; n < amount; n++) begin
      for (int j = 0; j < 3; j++) begin
        t[8*j +: 8] = {t[8*(j+1)], t[8*j+1 +: 7]};
        t[8*(j+4) +: 8] = {t[8*(j+5)], t[8*(j+4)+1 +: 7]};
      end
      t[31:24] = {t[3], t[31:25]};
      t[63:56] = {t[35], t[63:57]};
    end
    return t;
  endfunction

  task automatic load_key_schedule(input logic [63:0] key);
    logic [63:0] k;
    k = spread_lanes(key, MAP_KEY);
    k[7:0] = {k[35:32], 4'h0};
    for (int i = 0; i < 16; i++) begin
      round_keys[i] = k;
      k = rotate_halves(k, SHIFT_COUNT[i]);
    end
  endtask

  function automatic logic [63:0] decrypt_half(input logic [63:0] word);
    logic [63:0] blk;
    blk = spread_lanes(word, MAP_INIT);
    for (int i = 0; i < 16; i++) begin
      blk = {blk[31:0], mix_half(round_keys[i], blk[31:0]) ^ blk[63:32]};
    end
    return gather_lanes(blk, MAP_FINAL);
  endfunction

  // Runs the network backward so that a chosen plaintext half can be produced.
  function automatic logic [63:0] encrypt_half(input logic [63:0] plain);
    logic [63:0] blk;
    logic [63:0] word;
    logic [31:0] lo_prev;
    for (int i = 0; i < 64; i++) begin
      blk[i] = plain[final_pos[i]];
    end
    for (int i = 15; i >= 0; i--) begin
      lo_prev = blk[63:32];
      blk = {blk[31:0] ^ mix_half(round_keys[i], lo_prev), lo_prev};
    end
    for (int i = 0; i < 64; i++) begin
      word[i] = blk[init_pos[i]];
    end
    return word;
  endfunction

  function automatic int one_hot_index(input logic [63:0] w);
    for (int j = 0; j < 64; j++) begin
      if (w[j]) begin
        return j;
      end
    end
    return 0;
  endfunction

  function automatic control_result_t decode_control_word(input logic [63:0] first_half,
                                                          input logic [63:0] second_half);
    control_result_t res;
    logic [63:0] a;
    logic [63:0] b;
    a = decrypt_half(first_half);
    b = decrypt_half(second_half);
    res.control_word = {3'b000, a[27:24], a[23], a[22:16], a[15], a[14:8], a[7],
                        a[6:0], b[63], 1'b0, b[62:32]};
    res.extra_byte = a[55:48];
    res.date_word = b[15:0];
    if (res.date_word == 16'hFFFF) begin
      res.date_word = b[31:16];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    control_result_t want;
    control_result_t got;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL feistel_des_control_word_decrypt");
      $finish;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      {got.date_word, got.extra_byte, got.control_word} = out_ch.data;
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected result", out_ch.data[63:0], '0);
      end else begin
        want = pending_words.pop_front();
        if (got.control_word !== want.control_word) begin
          report_mismatch("control_word", got.control_word, want.control_word);
        end
        if (got.extra_byte !== want.extra_byte) begin
          report_mismatch("extra_byte", 64'(got.extra_byte), 64'(want.extra_byte));
        end
        if (got.date_word !== want.date_word) begin
          report_mismatch("date_word", 64'(got.date_word), 64'(want.date_word));
        end
      end
    end
  end

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) begin
      @(negedge clk);
    end
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else begin
        gap = quiet ? 0 : $urandom_range(18);
        if (gap > 0) begin
          out_ch.ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_request(input logic [63:0] first_half, input logic [63:0] second_half);
    int gap;
    gap = quiet ? 0 : $urandom_range(18);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = {second_half, first_half};
    do @(posedge clk); while (!in_ch.ready);
    pending_words.push_back(decode_control_word(first_half, second_half));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_key(input logic [63:0] key);
    drain_results();
    cfg_we = 1'b1;
    cfg_data = key;
    load_key_schedule(key);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_field_extremes();
    send_request(64'h0, 64'h0);
    send_request('1, '1);
    send_request(64'h0, '1);
    send_request('1, 64'h0);
    send_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(64'h1, 64'h8000_0000_0000_0000);
    send_request(64'h8000_0000_0000_0000, 64'h1);
    send_request(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
  endtask

  task automatic test_reset_key();
    send_field_extremes();
    drain_results();
  endtask

  task automatic test_key_extremes();
    write_key('1);
    send_field_extremes();
    write_key(64'h0);
    send_request(rand64(), rand64());
    drain_results();
  endtask

  task automatic test_date_fallback();
    write_key(rand64());
    send_request(rand64(), encrypt_half({48'(rand64()), 16'hFFFF}));
    send_request(rand64(), encrypt_half({32'h0, 32'hFFFF_FFFF}));
    send_request(rand64(), encrypt_half({32'(rand64()), 16'h0000, 16'hFFFF}));
    send_request(rand64(), encrypt_half({48'(rand64()), 16'hFFFE}));
    drain_results();
  endtask

  task automatic test_backpressure();
    quiet = 1;
    hold_cycles = 400;
    repeat (60) send_request(rand64(), rand64());
    quiet = 0;
    drain_results();
  endtask

  task automatic test_drain_pause();
    repeat (20) send_request(rand64(), rand64());
    in_ch.valid = 1'b0;
    while (pending_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) send_request(rand64(), rand64());
    drain_results();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      write_key(rand64());
      for (int i = 0; i < 300; i++) begin
        if (i % 100 == 0) begin
          quiet = ($urandom_range(2) == 0);
        end
        send_request(rand64(), rand64());
      end
      quiet = 0;
    end
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    for (int i = 0; i < 64; i++) begin
      final_pos[i] = one_hot_index(gather_lanes(64'h1 << i, MAP_FINAL));
      init_pos[i] = one_hot_index(spread_lanes(64'h1 << i, MAP_INIT));
    end
    load_key_schedule(64'h0);
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_reset_key();
    test_key_extremes();
    test_date_fallback();
    test_backpressure();
    test_drain_pause();
    test_random_traffic();
    if (error_count == 0) begin
      $display("PASS feistel_des_control_word_decrypt");
    end else begin
      $display("FAIL feistel_des_control_word_decrypt");
    end
    $finish;
  end

endmodule
